### design/hybrid_multiclass_scheduler_top_defines.svh
// Assertion macros for the multiclass scheduler.
// Used by the top level only; no other dependencies.
`ifndef HYBRID_MULTICLASS_SCHEDULER_TOP_DEFINES_SVH
`define HYBRID_MULTICLASS_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define HMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define HMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/hms_pkg.sv
// Shared types and constants for the multiclass scheduler.
// Used by hms_table and hybrid_multiclass_scheduler_top.
package hms_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int TIME_W    = 16;
  localparam int ID_W      = 8;
  localparam int PRIO_W    = 8;
  localparam int CLS_W     = 2;
  localparam int WAIT_W    = 8;
  localparam int Q_W       = 3;

  localparam logic [CLS_W-1:0] CLS_RT    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_IA    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BATCH = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BAD   = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_PCOUNT = 1'b0;
  localparam logic REG_AGING  = 1'b1;

  localparam logic [Q_W-1:0]    Q_FEW    = 3'd4;
  localparam logic [Q_W-1:0]    Q_MID    = 3'd3;
  localparam logic [Q_W-1:0]    Q_MANY   = 3'd2;
  localparam logic [CNT_W-1:0]  IA_MID   = CNT_W'(3);
  localparam logic [CNT_W-1:0]  IA_MANY  = CNT_W'(6);
  localparam logic [Q_W-1:0]    QU_SAT   = 3'd7;
  localparam logic [WAIT_W-1:0] WAIT_SAT = 8'd255;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] rem;
    logic [PRIO_W-1:0] prio;
    logic [CLS_W-1:0]  cls;
    logic [WAIT_W-1:0] cwait;
    logic [TIME_W-1:0] first;
    logic              started;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage

### design/hms_table.sv
// Task table: one write port, one read port, registered read data.
// Depends on hms_pkg.
module hms_table
  import hms_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### design/hybrid_multiclass_scheduler_top.sv
// Multiclass task scheduler with aging: sequencer around the task table.
// Depends on hms_pkg, hms_table and hybrid_multiclass_scheduler_top_defines.svh.
//
// channel  dir  handshake           payload
// in_      in   in_tvalid/in_tready  tdata: task fields, tuser: command
// out_     out  out_tvalid/out_tready tdata: tick report
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load item writes the table, then reports. A tick makes one pass over the
// table for n active slots (one read and one write-back a cycle), then the
// decision, the round robin start and search, and a read-modify-write of the
// running task. Reset is synchronous; no table clearing. A full output
// register stalls only the final step.
`include "hybrid_multiclass_scheduler_top_defines.svh"
module hybrid_multiclass_scheduler_top
  import hms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // slot, task_id, arrival, burst_length, priority_level, start_class
  input  logic [0:0]  in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata, // tick_time, running_id, dispatched, preempted, quantum_expired,
                                 // quantum_now, promoted_count, finished_id, turnaround,
                                 // waiting, response, all_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_RR     = 3'd4;
  localparam logic [2:0] S_SW     = 3'd5;
  localparam logic [2:0] S_EX     = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    pc_r;
  logic [WAIT_W-1:0]   thr_r;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic                run_vld_r, run_vld_nxt;
  logic [SLOT_W-1:0]   run_r, run_nxt;
  logic                lrr_vld_r, lrr_vld_nxt;
  logic [SLOT_W-1:0]   lrr_r, lrr_nxt;
  logic [Q_W-1:0]      ql_r, ql_nxt, qu_r, qu_nxt;
  logic [MAX_TASKS-1:0] busy_r, busy_nxt;

  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [SLOT_W-1:0]   pidx_r, pidx_nxt;
  logic                rt_f_r, rt_f_nxt;
  logic [SLOT_W-1:0]   rt_r, rt_nxt;
  logic [PRIO_W-1:0]   rt_prio_r, rt_prio_nxt;
  logic                b_f_r, b_f_nxt;
  logic [SLOT_W-1:0]   b_r, b_nxt;
  logic [TIME_W-1:0]   b_rem_r, b_rem_nxt;
  logic [CNT_W-1:0]    ia_cnt_r, ia_cnt_nxt;
  logic [MAX_TASKS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]    prom_r, prom_nxt;
  logic [CLS_W-1:0]    run_cls_r, run_cls_nxt;
  logic                nx_vld_r, nx_vld_nxt;
  logic [SLOT_W-1:0]   nx_r, nx_nxt;
  logic [CLS_W-1:0]    nx_cls_r, nx_cls_nxt;
  logic [CNT_W-1:0]    start_r, start_nxt;
  logic [SLOT_W-1:0]   j_r, j_nxt;

  // result fields of the item in flight
  logic [ID_W-1:0]     r_run_r, r_run_nxt;
  logic                r_disp_r, r_disp_nxt, r_pre_r, r_pre_nxt, r_exp_r, r_exp_nxt;
  logic [Q_W-1:0]      r_qnow_r, r_qnow_nxt;
  logic [ID_W-1:0]     r_fin_r, r_fin_nxt;
  logic [TIME_W-1:0]   r_tat_r, r_tat_nxt, r_wt_r, r_wt_nxt, r_rt_r, r_rt_nxt;
  logic                r_tick_r, r_tick_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [95:0]         out_data_r, out_data_nxt;

  mem_req_t            req;
  entry_t              rd;
  entry_t              ld, sc, ex;

  logic [CNT_W-1:0]    n_w;
  logic [MAX_TASKS-1:0] act_mask;
  logic                all_done;
  logic                in_acc;
  logic                rdy, run_ia, differ, ia_run;
  logic [TIME_W-1:0]   tat;
  logic [CNT_W-1:0]    j_inc;

  hms_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rd)
  );

  assign n_w       = (pc_r > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : pc_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      act_mask[i] = (CNT_W'(i) < n_w);
    end
  end
  assign all_done = ((busy_r & act_mask) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= CNT_W'(1);
      thr_r <= WAIT_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index[0])
        REG_PCOUNT: pc_r  <= cfg_data[CNT_W-1:0];
        REG_AGING:  thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    time_nxt    = time_r;
    run_vld_nxt = run_vld_r;
    run_nxt     = run_r;
    lrr_vld_nxt = lrr_vld_r;
    lrr_nxt     = lrr_r;
    ql_nxt      = ql_r;
    qu_nxt      = qu_r;
    busy_nxt    = busy_r;
    rd_cnt_nxt  = rd_cnt_r;
    pv_nxt      = 1'b0;
    pidx_nxt    = pidx_r;
    rt_f_nxt    = rt_f_r;
    rt_nxt      = rt_r;
    rt_prio_nxt = rt_prio_r;
    b_f_nxt     = b_f_r;
    b_nxt       = b_r;
    b_rem_nxt   = b_rem_r;
    ia_cnt_nxt  = ia_cnt_r;
    mask_nxt    = mask_r;
    prom_nxt    = prom_r;
    run_cls_nxt = run_cls_r;
    nx_vld_nxt  = nx_vld_r;
    nx_nxt      = nx_r;
    nx_cls_nxt  = nx_cls_r;
    start_nxt   = start_r;
    j_nxt       = j_r;
    r_run_nxt   = r_run_r;
    r_disp_nxt  = r_disp_r;
    r_pre_nxt   = r_pre_r;
    r_exp_nxt   = r_exp_r;
    r_qnow_nxt  = r_qnow_r;
    r_fin_nxt   = r_fin_r;
    r_tat_nxt   = r_tat_r;
    r_wt_nxt    = r_wt_r;
    r_rt_nxt    = r_rt_r;
    r_tick_nxt  = r_tick_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    req         = '0;
    rdy         = 1'b0;
    run_ia      = 1'b0;
    differ      = 1'b0;
    ia_run      = 1'b0;
    tat         = '0;
    j_inc       = '0;

    ld.id      = in_tdata[11:4];
    ld.arr     = in_tdata[27:12];
    ld.burst   = in_tdata[43:28];
    ld.rem     = in_tdata[43:28];
    ld.prio    = in_tdata[51:44];
    ld.cls     = (in_tdata[53:52] == CLS_BAD) ? CLS_BATCH : in_tdata[53:52];
    ld.cwait   = '0;
    ld.first   = '0;
    ld.started = 1'b0;
    sc = rd;
    ex = rd;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          r_run_nxt  = '0;
          r_disp_nxt = 1'b0;
          r_pre_nxt  = 1'b0;
          r_exp_nxt  = 1'b0;
          r_qnow_nxt = '0;
          r_fin_nxt  = '0;
          r_tat_nxt  = '0;
          r_wt_nxt   = '0;
          r_rt_nxt   = '0;
          prom_nxt   = '0;
          if (in_tuser[0] == CMD_LOAD) begin
            r_tick_nxt = 1'b0;
            req.we    = 1'b1;
            req.waddr = in_tdata[3:0];
            req.wdata = ld;
            busy_nxt[in_tdata[3:0]] = (ld.burst != '0);
            if (run_vld_r && run_r == in_tdata[3:0]) begin
              run_vld_nxt = 1'b0;
            end
            state_nxt = S_OUT;
          end else begin
            r_tick_nxt = 1'b1;
            if (run_vld_r && ((CNT_W'(run_r) >= n_w) || !busy_r[run_r])) begin
              run_vld_nxt = 1'b0;
            end
            rd_cnt_nxt = '0;
            rt_f_nxt   = 1'b0;
            b_f_nxt    = 1'b0;
            ia_cnt_nxt = '0;
            mask_nxt   = '0;
            run_cls_nxt = CLS_BATCH;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_cnt_r < n_w) begin
          req.re     = 1'b1;
          req.raddr  = rd_cnt_r[SLOT_W-1:0];
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          pv_nxt     = 1'b1;
          pidx_nxt   = rd_cnt_r[SLOT_W-1:0];
        end
        if (pv_r) begin
          rdy = (rd.arr <= time_r) && (rd.rem != '0);
          if (run_vld_r && pidx_r == run_r) begin
            run_cls_nxt = rd.cls;
          end
          // age waiting tasks; the running one is left alone
          if (rdy && !(run_vld_r && pidx_r == run_r)) begin
            if (sc.cwait != WAIT_SAT) begin
              sc.cwait = sc.cwait + 1'b1;
            end
            if (sc.cwait >= thr_r && sc.cls != CLS_RT) begin
              sc.cls   = sc.cls - 1'b1;
              sc.cwait = '0;
              prom_nxt = prom_r + 1'b1;
            end
          end
          req.we    = 1'b1;
          req.waddr = pidx_r;
          req.wdata = sc;
          if (rdy) begin
            case (sc.cls)
              CLS_RT: begin
                if (!rt_f_r || sc.prio < rt_prio_r) begin
                  rt_f_nxt    = 1'b1;
                  rt_nxt      = pidx_r;
                  rt_prio_nxt = sc.prio;
                end
              end
              CLS_IA: begin
                ia_cnt_nxt       = ia_cnt_r + 1'b1;
                mask_nxt[pidx_r] = 1'b1;
              end
              CLS_BATCH: begin
                if (!b_f_r || sc.rem < b_rem_r) begin
                  b_f_nxt   = 1'b1;
                  b_nxt     = pidx_r;
                  b_rem_nxt = sc.rem;
                end
              end
              default: ;
            endcase
          end
        end else if (rd_cnt_r >= n_w) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        run_ia = run_vld_r && (run_cls_r == CLS_IA);
        if (rt_f_r) begin
          nx_vld_nxt = 1'b1;
          nx_nxt     = rt_r;
          nx_cls_nxt = CLS_RT;
          state_nxt  = S_SW;
        end else if (run_ia && qu_r < ql_r) begin
          nx_vld_nxt = 1'b1;
          nx_nxt     = run_r;
          nx_cls_nxt = CLS_IA;
          state_nxt  = S_SW;
        end else begin
          r_exp_nxt = run_ia;
          if (ia_cnt_r != '0) begin
            ql_nxt = (ia_cnt_r >= IA_MANY) ? Q_MANY : ((ia_cnt_r >= IA_MID) ? Q_MID : Q_FEW);
            qu_nxt = '0;
            start_nxt = lrr_vld_r ? (CNT_W'(lrr_r) + 1'b1) : '0;
            state_nxt = S_MOD;
          end else begin
            nx_vld_nxt = b_f_r;
            nx_nxt     = b_r;
            nx_cls_nxt = CLS_BATCH;
            state_nxt  = S_SW;
          end
        end
      end
      S_MOD: begin
        // reduce the round robin start below the slot count
        if (start_r >= n_w) begin
          start_nxt = start_r - n_w;
        end else begin
          j_nxt     = start_r[SLOT_W-1:0];
          state_nxt = S_RR;
        end
      end
      S_RR: begin
        j_inc = CNT_W'(j_r) + 1'b1;
        if (mask_r[j_r]) begin
          nx_vld_nxt  = 1'b1;
          nx_nxt      = j_r;
          nx_cls_nxt  = CLS_IA;
          lrr_vld_nxt = 1'b1;
          lrr_nxt     = j_r;
          state_nxt   = S_SW;
        end else begin
          j_nxt = (j_inc >= n_w) ? '0 : j_inc[SLOT_W-1:0];
        end
      end
      S_SW: begin
        differ = (nx_vld_r != run_vld_r) || (nx_vld_r && nx_r != run_r);
        ia_run = (run_cls_r == CLS_IA);
        if (differ) begin
          r_pre_nxt  = run_vld_r && (!ia_run || nx_vld_r) && (!ia_run || qu_r < ql_r);
          r_disp_nxt = nx_vld_r;
          if (nx_vld_r && nx_cls_r != CLS_IA) begin
            qu_nxt = '0;
          end
          run_vld_nxt = nx_vld_r;
          run_nxt     = nx_r;
        end
        if (nx_vld_r) begin
          req.re    = 1'b1;
          req.raddr = nx_r;
          state_nxt = S_EX;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EX: begin
        tat = (time_r + 1'b1) - rd.arr;
        if (r_disp_r && !rd.started) begin
          ex.first   = time_r;
          ex.started = 1'b1;
        end
        ex.rem   = rd.rem - 1'b1;
        ex.cwait = '0;
        req.we    = 1'b1;
        req.waddr = run_r;
        req.wdata = ex;
        r_run_nxt  = rd.id;
        r_qnow_nxt = (rd.cls == CLS_IA) ? ql_r : '0;
        if (qu_r != QU_SAT) begin
          qu_nxt = qu_r + 1'b1;
        end
        if (ex.rem == '0) begin
          r_fin_nxt   = rd.id;
          r_tat_nxt   = tat;
          r_wt_nxt    = (tat >= rd.burst) ? (tat - rd.burst) : '0;
          r_rt_nxt    = ex.first - rd.arr;
          busy_nxt[run_r] = 1'b0;
          run_vld_nxt = 1'b0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {4'd0, all_done, r_rt_r, r_wt_r, r_tat_r, r_fin_r, prom_r,
                          r_qnow_r, r_exp_r, r_pre_r, r_disp_r, r_run_r,
                          r_tick_r ? time_r : TIME_W'(0)};
          if (r_tick_r) begin
            time_nxt = time_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      time_r    <= '0;
      run_vld_r <= 1'b0;
      lrr_vld_r <= 1'b0;
      ql_r      <= '0;
      qu_r      <= '0;
      busy_r    <= '0;
      pv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      run_vld_r <= run_vld_nxt;
      lrr_vld_r <= lrr_vld_nxt;
      ql_r      <= ql_nxt;
      qu_r      <= qu_nxt;
      busy_r    <= busy_nxt;
      pv_r      <= pv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r      <= run_nxt;
    lrr_r      <= lrr_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    pidx_r     <= pidx_nxt;
    rt_f_r     <= rt_f_nxt;
    rt_r       <= rt_nxt;
    rt_prio_r  <= rt_prio_nxt;
    b_f_r      <= b_f_nxt;
    b_r        <= b_nxt;
    b_rem_r    <= b_rem_nxt;
    ia_cnt_r   <= ia_cnt_nxt;
    mask_r     <= mask_nxt;
    prom_r     <= prom_nxt;
    run_cls_r  <= run_cls_nxt;
    nx_vld_r   <= nx_vld_nxt;
    nx_r       <= nx_nxt;
    nx_cls_r   <= nx_cls_nxt;
    start_r    <= start_nxt;
    j_r        <= j_nxt;
    r_run_r    <= r_run_nxt;
    r_disp_r   <= r_disp_nxt;
    r_pre_r    <= r_pre_nxt;
    r_exp_r    <= r_exp_nxt;
    r_qnow_r   <= r_qnow_nxt;
    r_fin_r    <= r_fin_nxt;
    r_tat_r    <= r_tat_nxt;
    r_wt_r     <= r_wt_nxt;
    r_rt_r     <= r_rt_nxt;
    r_tick_r   <= r_tick_nxt;
    out_data_r <= out_data_nxt;
  end

  `HMS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item taken mid-work")
  `HMS_ASSERT_IMPL(a_run_busy, state_r == S_IDLE && run_vld_r, busy_r[run_r], "running slot idle")
  `HMS_ASSERT_IMPL(a_out_src, $rose(out_tvalid), $past(state_r == S_OUT), "stray result")
  `HMS_ASSERT_IMPL(a_rr_hit, state_r == S_RR, mask_r != '0, "round robin search with no candidate")

endmodule

### tb/hybrid_multiclass_scheduler_top_tb.sv
// Self-checking testbench for the multiclass scheduler: a directed table, then random task sets.
// Results are predicted in the bench and compared field by field. Depends on hms_pkg.
`timescale 1ns / 100ps
module hybrid_multiclass_scheduler_top_tb;
  import hms_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 100;

  typedef struct {
    logic [15:0] tick;
    logic [7:0]  run_id;
    logic        disp;
    logic        pre;
    logic        qexp;
    logic [2:0]  qnow;
    logic [4:0]  promo;
    logic [7:0]  fin_id;
    logic [15:0] tat;
    logic [15:0] wt;
    logic [15:0] rt;
    logic        done;
  } report_t;

  typedef struct {
    logic        cmd;
    logic [3:0]  slot;
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [1:0]  cls;
    bit          has_done;  // all_done typed in for this row
    logic        done;
  } row_t;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [55:0] in_tdata;  // slot, task_id, arrival, burst_length, priority_level, start_class
  logic [0:0]  in_tuser;  // command
  logic        out_tvalid, out_tready;
  logic [95:0] out_tdata; // tick_time, running_id, dispatched, preempted, quantum_expired,
                          // quantum_now, promoted_count, finished_id, turnaround, waiting,
                          // response, all_done
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  hybrid_multiclass_scheduler_top u_dut (.*);

  // scheduler state mirror
  logic [7:0]  t_id    [MAX_TASKS];
  logic [15:0] t_arr   [MAX_TASKS];
  logic [15:0] t_burst [MAX_TASKS];
  logic [15:0] t_rem   [MAX_TASKS];
  logic [7:0]  t_prio  [MAX_TASKS];
  logic [1:0]  t_cls   [MAX_TASKS];
  logic [7:0]  t_wait  [MAX_TASKS];
  logic [15:0] t_first [MAX_TASKS];
  logic        t_start [MAX_TASKS];
  logic [15:0] now;
  int          run_slot, rr_last;
  logic [2:0]  qlen, qused;
  logic [4:0]  done_cnt;
  logic [4:0]  pcount;
  logic [7:0]  age_thr;

  report_t reports_due[$];
  int      fails, cycles, items;

  function automatic int active_n();
    return (pcount > MAX_TASKS) ? MAX_TASKS : int'(pcount);
  endfunction

  function automatic bit task_ready(int i);
    return t_arr[i] <= now && t_rem[i] != 0;
  endfunction

  function automatic logic all_finished();
    for (int i = 0; i < active_n(); i++)
      if (t_rem[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic report_t schedule_item(row_t it);
    report_t r;
    int n, nxt, ready_ia, start, j, s;
    bit run_ia, ia;
    r = '{default: '0};
    n = active_n();
    nxt = -1;
    ready_ia = 0;
    if (it.cmd == CMD_LOAD) begin
      s = it.slot;
      t_id[s] = it.id; t_arr[s] = it.arr; t_burst[s] = it.burst; t_rem[s] = it.burst;
      t_prio[s] = it.prio; t_cls[s] = (it.cls == CLS_BAD) ? CLS_BATCH : it.cls;
      t_wait[s] = 0; t_first[s] = 0; t_start[s] = 0;
      if (run_slot == s) run_slot = -1;
      r.done = all_finished();
      return r;
    end
    r.tick = now;
    if (run_slot >= 0 && (run_slot >= n || t_rem[run_slot] == 0)) run_slot = -1;
    // aging
    for (int i = 0; i < n; i++) begin
      if (!task_ready(i) || i == run_slot) continue;
      if (t_wait[i] != 8'hFF) t_wait[i]++;
      if (t_wait[i] >= age_thr && t_cls[i] != CLS_RT) begin
        t_cls[i]--;
        t_wait[i] = 0;
        r.promo++;
      end
    end
    for (int i = 0; i < n; i++)
      if (task_ready(i) && t_cls[i] == CLS_RT && (nxt < 0 || t_prio[i] < t_prio[nxt]))
        nxt = i;
    if (nxt < 0) begin
      run_ia = run_slot >= 0 && t_cls[run_slot] == CLS_IA;
      if (run_ia && qused < qlen) nxt = run_slot;
      else begin
        if (run_ia) r.qexp = 1'b1;
        for (int i = 0; i < n; i++)
          if (task_ready(i) && t_cls[i] == CLS_IA) ready_ia++;
        if (ready_ia > 0) begin
          qlen = (ready_ia >= IA_MANY) ? Q_MANY : (ready_ia >= IA_MID) ? Q_MID : Q_FEW;
          qused = 0;
          start = (rr_last < 0) ? 0 : (rr_last + 1) % n;
          for (int k = 0; k < n; k++) begin
            j = (start + k) % n;
            if (task_ready(j) && t_cls[j] == CLS_IA) begin
              nxt = j;
              rr_last = j;
              break;
            end
          end
        end
      end
    end
    if (nxt < 0)
      for (int i = 0; i < n; i++)
        if (task_ready(i) && t_cls[i] == CLS_BATCH && (nxt < 0 || t_rem[i] < t_rem[nxt]))
          nxt = i;
    if (nxt != run_slot) begin
      if (run_slot >= 0) begin
        ia = t_cls[run_slot] == CLS_IA;
        if ((!ia || nxt >= 0) && (!ia || qused < qlen)) r.pre = 1'b1;
      end
      if (nxt >= 0) begin
        r.disp = 1'b1;
        if (!t_start[nxt]) begin
          t_first[nxt] = r.tick;
          t_start[nxt] = 1'b1;
        end
        if (t_cls[nxt] != CLS_IA) qused = 0;
      end
      run_slot = nxt;
    end
    now = r.tick + 16'd1;
    if (run_slot >= 0) begin
      s = run_slot;
      r.run_id = t_id[s];
      r.qnow = (t_cls[s] == CLS_IA) ? qlen : 3'd0;
      t_rem[s]--;
      t_wait[s] = 0;
      if (qused != QU_SAT) qused++;
      if (t_rem[s] == 0) begin
        r.fin_id = t_id[s];
        r.tat = now - t_arr[s];
        r.wt = (r.tat >= t_burst[s]) ? r.tat - t_burst[s] : 16'd0;
        r.rt = t_first[s] - t_arr[s];
        if (done_cnt != 5'd31) done_cnt++;
        run_slot = -1;
      end
    end
    r.done = all_finished();
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("hybrid_multiclass_scheduler_top_tb: FAIL");
      $finish;
    end
  end

  // receiver stall patterns, picked at random
  int rx_mode, rx_cnt;
  always @(negedge clk) begin
    rx_cnt++;
    if (rx_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= (rx_cnt % 4 == 0);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    report_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a.tick = out_tdata[15:0];   a.run_id = out_tdata[23:16];
      a.disp = out_tdata[24];     a.pre = out_tdata[25];       a.qexp = out_tdata[26];
      a.qnow = out_tdata[29:27];  a.promo = out_tdata[34:30];  a.fin_id = out_tdata[42:35];
      a.tat = out_tdata[58:43];   a.wt = out_tdata[74:59];     a.rt = out_tdata[90:75];
      a.done = out_tdata[91];
      if (reports_due.size() == 0) begin
        $error("unexpected result item");
        fails++;
      end else begin
        e = reports_due.pop_front();
        if (a.tick !== e.tick) begin
          $error("tick_time exp %0d got %0d", e.tick, a.tick); fails++;
        end
        if (a.run_id !== e.run_id) begin
          $error("running_id exp %0d got %0d", e.run_id, a.run_id); fails++;
        end
        if (a.disp !== e.disp) begin
          $error("dispatched exp %0d got %0d", e.disp, a.disp); fails++;
        end
        if (a.pre !== e.pre) begin
          $error("preempted exp %0d got %0d", e.pre, a.pre); fails++;
        end
        if (a.qexp !== e.qexp) begin
          $error("quantum_expired exp %0d got %0d", e.qexp, a.qexp); fails++;
        end
        if (a.qnow !== e.qnow) begin
          $error("quantum_now exp %0d got %0d", e.qnow, a.qnow); fails++;
        end
        if (a.promo !== e.promo) begin
          $error("promoted_count exp %0d got %0d", e.promo, a.promo); fails++;
        end
        if (a.fin_id !== e.fin_id) begin
          $error("finished_id exp %0d got %0d", e.fin_id, a.fin_id); fails++;
        end
        if (a.tat !== e.tat) begin
          $error("turnaround exp %0d got %0d", e.tat, a.tat); fails++;
        end
        if (a.wt !== e.wt) begin
          $error("waiting exp %0d got %0d", e.wt, a.wt); fails++;
        end
        if (a.rt !== e.rt) begin
          $error("response exp %0d got %0d", e.rt, a.rt); fails++;
        end
        if (a.done !== e.done) begin
          $error("all_done exp %0d got %0d", e.done, a.done); fails++;
        end
      end
    end
  end

  task automatic push_item(row_t it);
    report_t r;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {2'b00, it.cls, it.prio, it.burst, it.arr, it.id, it.slot};
    do @(posedge clk); while (!in_tready);
    r = schedule_item(it);
    if (it.has_done && r.done !== it.done) begin
      $error("all_done table exp %0d predicted %0d", it.done, r.done);
      fails++;
    end
    reports_due.push_back(r);
    items++;
  endtask

  // sender gap after an item; zero keeps the burst going
  task automatic sender_gap(int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_all();
    sender_gap(1);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PCOUNT) pcount = val[4:0];
    else age_thr = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic row_t tick_row();
    row_t t;
    t = '{default: '0};
    t.cmd = CMD_TICK;
    t.slot = $urandom; t.id = $urandom; t.arr = $urandom; t.burst = $urandom;
    return t;
  endfunction

  function automatic row_t load_row(int s, bit noisy);
    row_t t;
    t = '{default: '0};
    t.cmd = CMD_LOAD;
    t.slot = s;
    t.id = $urandom_range(1, 255);
    t.prio = $urandom;
    t.cls = $urandom_range(0, 3);
    if (!noisy) begin
      t.arr = now + $urandom_range(0, 5);
      t.burst = $urandom_range(1, 7);
    end else begin
      case ($urandom_range(0, 3))
        0: t.burst = 16'd0;
        1: t.burst = 16'hFFFF;
        2: t.burst = $urandom;
        default: t.burst = $urandom_range(1, 12);
      endcase
      t.arr = $urandom_range(0, 1) ? 16'($urandom) : now + $urandom_range(0, 3);
      t.id = $urandom;
    end
    return t;
  endfunction

  function automatic row_t mk(logic cmd, int s, int id, int arr, int burst, int prio,
                              int cls, bit hd, logic dn);
    row_t t;
    t = '{cmd, s, id, arr, burst, prio, cls, hd, dn};
    return t;
  endfunction

  row_t dir_rows[$];

  initial begin
    int gap, nt, pc;
    row_t t;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    out_tready = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    fails = 0; cycles = 0; items = 0; rx_mode = 0; rx_cnt = 0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      t_id[i] = 0; t_arr[i] = 0; t_burst[i] = 0; t_rem[i] = 0; t_prio[i] = 0;
      t_cls[i] = 0; t_wait[i] = 0; t_first[i] = 0; t_start[i] = 0;
    end
    now = 0; run_slot = -1; rr_last = -1; qlen = 0; qused = 0; done_cnt = 0;
    pcount = 5'd1; age_thr = 8'd10;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every slot written before any wider scan can read it
    for (int i = 0; i < MAX_TASKS; i++)
      push_item(mk(CMD_LOAD, i, i + 1, 0, 0, 0, CLS_BATCH, 1, 1'b1));
    drain_all();
    write_reg(REG_PCOUNT, 8'd4);
    write_reg(REG_AGING, 8'd3);

    dir_rows.push_back(mk(CMD_LOAD, 0, 255, 0, 3, 255, CLS_RT, 1, 1'b0));
    dir_rows.push_back(mk(CMD_LOAD, 1, 1, 0, 5, 0, CLS_IA, 1, 1'b0));
    dir_rows.push_back(mk(CMD_LOAD, 2, 2, 1, 2, 9, CLS_BATCH, 1, 1'b0));
    // class 3 loads as batch; arrival at the top of the range never becomes ready
    dir_rows.push_back(mk(CMD_LOAD, 3, 3, 16'hFFFF, 16'hFFFF, 128, CLS_BAD, 1, 1'b0));
    repeat (8) dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    // reload whatever may be running, and a zero burst
    dir_rows.push_back(mk(CMD_LOAD, 1, 4, 0, 4, 1, CLS_IA, 0, 1'b0));
    dir_rows.push_back(mk(CMD_LOAD, 2, 5, 0, 0, 2, CLS_BATCH, 0, 1'b0));
    dir_rows.push_back(mk(CMD_LOAD, 3, 6, 0, 2, 3, CLS_BATCH, 0, 1'b0));
    repeat (8) dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    foreach (dir_rows[i]) begin
      push_item(dir_rows[i]);
      sender_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 5));
    end

    // zero and oversize process counts, one tick on the first and two on the second
    drain_all();
    write_reg(REG_PCOUNT, 8'd0);
    push_item(tick_row());
    drain_all();
    write_reg(REG_PCOUNT, 8'hFF);
    write_reg(REG_AGING, 8'd0);
    push_item(tick_row());
    push_item(tick_row());

    while (items < 470) begin
      drain_all();
      case ($urandom_range(0, 9))
        0: pc = 0;
        1: pc = 16;
        2: pc = $urandom_range(17, 255);
        default: pc = $urandom_range(1, 8);
      endcase
      write_reg(REG_PCOUNT, pc);
      case ($urandom_range(0, 7))
        0: write_reg(REG_AGING, 8'd0);
        1: write_reg(REG_AGING, 8'd255);
        2: write_reg(REG_AGING, $urandom);
        default: write_reg(REG_AGING, $urandom_range(1, 6));
      endcase
      for (int s = 0; s < active_n(); s++) begin
        push_item(load_row(s, $urandom_range(0, 9) == 0));
        sender_gap(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
      end
      nt = $urandom_range(10, 40);
      for (int k = 0; k < nt; k++) begin
        if ($urandom_range(0, 9) == 0)
          t = load_row($urandom_range(0, MAX_TASKS - 1), $urandom_range(0, 1));
        else
          t = tick_row();
        push_item(t);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        sender_gap(gap);
      end
    end

    drain_all();
    if (fails == 0) begin
      $display("hybrid_multiclass_scheduler_top_tb: PASS");
    end else begin
      $display("hybrid_multiclass_scheduler_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/hms_pkg.sv
design/hms_table.sv
design/hybrid_multiclass_scheduler_top.sv
tb/hybrid_multiclass_scheduler_top_tb.sv
